FILE: rtl/pac_pkg.sv
// shared types, codes and constants of the polygon area and centroid block
package pac_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int ACC_W          = 64;
    localparam int TYPE_W         = 5;
    localparam int CNT_W          = 6;

    localparam logic [TYPE_W-1:0] TYPE_POLYGON    = 5'd5;
    localparam logic [TYPE_W-1:0] TYPE_POLYGON_Z  = 5'd15;
    localparam logic [TYPE_W-1:0] TYPE_POLYGON_M  = 5'd25;
    localparam logic [TYPE_W-1:0] TYPE_MULTIPATCH = 5'd31;
    localparam logic [TYPE_W-1:0] TYPE_RESET      = TYPE_POLYGON;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_AREA = 2'd1,
        ST_ZERO     = 2'd2,
        ST_OVF      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POS_BASE   = 2'd0,
        POS_SECOND = 2'd1,
        POS_FAN    = 2'd2
    } ring_pos_t;

    typedef enum logic {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } mdu_op_t;

    // request and response of the shared multiply/divide unit
    typedef struct packed {
        logic    start;
        mdu_op_t op;
    } mdu_req_t;

    typedef struct packed {
        logic done;
        logic flag;
    } mdu_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FAN_M1,
        S_FAN_M2,
        S_FAN_AREA,
        S_FAN_M3,
        S_FAN_MX,
        S_FAN_M4,
        S_FAN_MY,
        S_CLOSE,
        S_C_ADDY,
        S_C_M1,
        S_C_ADD1,
        S_C_M2,
        S_C_ADD2,
        S_C_DEN,
        S_END,
        S_DIV_X,
        S_DIV_Y,
        S_OUT
    } seq_state_t;

    // signed overflow of a two's complement add
    function automatic logic add_ovf(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b,
                                     input logic [ACC_W-1:0] s);
        add_ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
    endfunction

endpackage

FILE: rtl/pac_mdu.sv
// shared iterative multiply/divide unit, one bit per cycle on one 65-bit adder
module pac_mdu (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pac_pkg::mdu_req_t           req,
    input  logic [pac_pkg::ACC_W-1:0]   a,
    input  logic [pac_pkg::ACC_W-1:0]   b,
    output pac_pkg::mdu_rsp_t           rsp,
    output logic [pac_pkg::ACC_W-1:0]   res
);

    localparam int W = pac_pkg::ACC_W;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [pac_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    pac_pkg::mdu_op_t           op_reg, op_next;
    logic                       neg_reg, neg_next;
    logic [W-1:0]               m_reg, m_next;
    logic [W-1:0]               hi_reg, hi_next;
    logic [W-1:0]               lo_reg, lo_next;

    logic [W-1:0]               mag_a, mag_b, shifted_rem, lim, neg_lo;
    logic [W:0]                 add_l, add_r, sum;
    logic                       is_div, mul_ovf;

    // magnitudes of the operands
    assign mag_a = a[W-1] ? (W'(0) - a) : a;
    assign mag_b = b[W-1] ? (W'(0) - b) : b;

    // one shared adder: add multiplicand or subtract divisor
    assign is_div      = (op_reg == pac_pkg::MDU_DIV);
    assign shifted_rem = {hi_reg[W-2:0], lo_reg[W-1]};
    assign add_l       = is_div ? {1'b0, shifted_rem} : {1'b0, hi_reg};
    assign add_r       = is_div ? ~{1'b0, m_reg} : (lo_reg[0] ? {1'b0, m_reg} : '0);
    assign sum         = add_l + add_r + {{W{1'b0}}, is_div};

    // result of a finished operation
    assign lim     = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign mul_ovf = (|hi_reg) || (lo_reg > lim);
    assign neg_lo  = W'(0) - lo_reg;
    assign res     = is_div ? lo_reg : (neg_reg ? neg_lo : lo_reg);
    assign rsp.done = done_reg;
    assign rsp.flag = is_div ? neg_reg : mul_ovf;

    // iteration control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        neg_next  = neg_reg;
        m_next    = m_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = req.op;
            neg_next  = a[W-1] ^ b[W-1];
            hi_next   = '0;
            if (req.op == pac_pkg::MDU_DIV)
            begin
                m_next  = mag_b;
                lo_next = mag_a;
            end
            else
            begin
                m_next  = mag_a;
                lo_next = mag_b;
            end
        end
        else if (busy_reg)
        begin
            if (is_div)
            begin
                if (!sum[W])
                begin
                    hi_next = sum[W-1:0];
                    lo_next = {lo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    hi_next = shifted_rem;
                    lo_next = {lo_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                hi_next = sum[W:1];
                lo_next = {sum[0], lo_reg[W-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (&cnt_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= pac_pkg::MDU_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        m_reg   <= m_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
    end

endmodule

FILE: rtl/polygon_area_centroid.sv
// polygon area and centroid: sequencer, accumulators and result register
//
//  channel   signals                          direction  moves
//  in        in_valid/in_ready x y ring_last  into block one vertex request
//            shape_last
//  out       out_valid/out_ready cx cy status out        one centroid request
//  cfg       cfg_valid/cfg_ready shape_type   into block shape type write
//
// a fan vertex takes four passes of the shared multiply/divide unit plus
// accumulate steps; a closing vertex takes two passes unless its ring area
// is zero, and a shape end with no error two more for the divides; base and
// second vertices take no pass of the unit
// reset clears all ring and shape sums and sets shape_type to 5
// a result waiting on out_ready holds the sequencer in its last state only
// when a second result is ready; inputs are taken meanwhile up to that point
module polygon_area_centroid #(
    parameter int COORD_BITS = pac_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    input  logic                        ring_last,
    input  logic                        shape_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [COORD_BITS-1:0] cx,
    output logic signed [COORD_BITS-1:0] cy,
    output logic [1:0]                  status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pac_pkg::TYPE_W-1:0]  shape_type
);

    localparam int W     = pac_pkg::ACC_W;
    localparam int C     = COORD_BITS;
    localparam int OFF_W = COORD_BITS + 1;

    pac_pkg::seq_state_t state_reg, state_next;
    pac_pkg::ring_pos_t  pos_reg, pos_next;
    pac_pkg::status_t    err_reg, err_next;
    pac_pkg::status_t    st_reg, st_next;
    pac_pkg::status_t    out_st_reg, out_st_next;

    logic [pac_pkg::TYPE_W-1:0] type_reg, type_next;
    logic [C-1:0]     cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [C-1:0]     base_x_reg, base_x_next, base_y_reg, base_y_next;
    logic [OFF_W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic             last_reg, last_next;
    logic [W-1:0]     area_reg, area_next, mx_reg, mx_next, my_reg, my_next;
    logic [W-1:0]     nx_reg, nx_next, ny_reg, ny_next, den_reg, den_next;
    logic [W-1:0]     t1_reg, t1_next, cross_reg, cross_next, d3_reg, d3_next;
    logic [C-1:0]     rx_reg, rx_next, ry_reg, ry_next;
    logic [C-1:0]     out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic             out_valid_reg, out_valid_next;

    logic [C-1:0]     src_x, src_y;
    logic [W-1:0]     x64, y64, bx64, by64, ox, oy, ppx, ppy, bx3, by3;
    logic [W-1:0]     add_a, add_b, add_sum;
    logic             add_bad, is_area_type;
    logic [W+1:0]     den66, d3w;
    logic [W-1:0]     hi_lim, neg_mag;
    logic [C-1:0]     sat_val;

    pac_pkg::mdu_req_t mdu_req;
    pac_pkg::mdu_rsp_t mdu_rsp;
    logic [W-1:0]      mdu_a, mdu_b, mdu_res;

    pac_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mdu_req),
        .a     (mdu_a),
        .b     (mdu_b),
        .rsp   (mdu_rsp),
        .res   (mdu_res)
    );

    // offsets from the fan base, from the ports while idle
    assign src_x = (state_reg == pac_pkg::S_IDLE) ? x : cur_x_reg;
    assign src_y = (state_reg == pac_pkg::S_IDLE) ? y : cur_y_reg;
    assign x64   = {{(W-C){src_x[C-1]}}, src_x};
    assign y64   = {{(W-C){src_y[C-1]}}, src_y};
    assign bx64  = {{(W-C){base_x_reg[C-1]}}, base_x_reg};
    assign by64  = {{(W-C){base_y_reg[C-1]}}, base_y_reg};
    assign ox    = x64 - bx64;
    assign oy    = y64 - by64;
    assign ppx   = {{(W-OFF_W){prev_x_reg[OFF_W-1]}}, prev_x_reg};
    assign ppy   = {{(W-OFF_W){prev_y_reg[OFF_W-1]}}, prev_y_reg};
    assign bx3   = (bx64 << 1) + bx64;
    assign by3   = (by64 << 1) + by64;

    // shared accumulate adder
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        unique case (state_reg)
            pac_pkg::S_FAN_AREA: begin add_a = area_reg; add_b = cross_reg; end
            pac_pkg::S_FAN_MX:   begin add_a = mx_reg;   add_b = mdu_res;   end
            pac_pkg::S_FAN_MY:   begin add_a = my_reg;   add_b = mdu_res;   end
            pac_pkg::S_CLOSE:    begin add_a = nx_reg;   add_b = mx_reg;    end
            pac_pkg::S_C_ADDY:   begin add_a = ny_reg;   add_b = my_reg;    end
            pac_pkg::S_C_ADD1:   begin add_a = nx_reg;   add_b = mdu_res;   end
            pac_pkg::S_C_ADD2:   begin add_a = ny_reg;   add_b = mdu_res;   end
            pac_pkg::S_C_DEN:    begin add_a = den_reg;  add_b = area_reg;  end
            default:             begin add_a = '0;       add_b = '0;        end
        endcase
    end
    assign add_sum = add_a + add_b;
    assign add_bad = pac_pkg::add_ovf(add_a, add_b, add_sum);

    // three times the summed area, with range check
    assign den66 = {{2{den_reg[W-1]}}, den_reg};
    assign d3w   = (den66 << 1) + den66;

    // quotient magnitude and sign to a saturated coordinate
    assign hi_lim  = (W'(1) << (C-1)) - W'(1);
    assign neg_mag = W'(0) - mdu_res;
    always_comb
    begin
        if (!mdu_rsp.flag)
            sat_val = (mdu_res > hi_lim) ? hi_lim[C-1:0] : mdu_res[C-1:0];
        else
            sat_val = (mdu_res > hi_lim + W'(1)) ? ~hi_lim[C-1:0] : neg_mag[C-1:0];
    end

    assign is_area_type = (type_reg == pac_pkg::TYPE_POLYGON)   ||
                          (type_reg == pac_pkg::TYPE_POLYGON_Z) ||
                          (type_reg == pac_pkg::TYPE_POLYGON_M) ||
                          (type_reg == pac_pkg::TYPE_MULTIPATCH);

    assign in_ready  = (state_reg == pac_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign cx        = out_x_reg;
    assign cy        = out_y_reg;
    assign status    = out_st_reg;

    // sequencer: next state, accumulators and unit requests
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        err_next       = err_reg;
        st_next        = st_reg;
        out_st_next    = out_st_reg;
        type_next      = type_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        last_next      = last_reg;
        area_next      = area_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        den_next       = den_reg;
        t1_next        = t1_reg;
        cross_next     = cross_reg;
        d3_next        = d3_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_valid_next = out_valid_reg;
        mdu_req.start  = 1'b0;
        mdu_req.op     = pac_pkg::MDU_MUL;
        mdu_a          = '0;
        mdu_b          = '0;

        if (cfg_valid)
            type_next = shape_type;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            pac_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_x_next = x;
                    cur_y_next = y;
                    last_next  = shape_last;
                    if (ring_last || shape_last)
                        state_next = pac_pkg::S_CLOSE;
                    else if (pos_reg == pac_pkg::POS_BASE)
                    begin
                        base_x_next = x;
                        base_y_next = y;
                        pos_next    = pac_pkg::POS_SECOND;
                        state_next  = pac_pkg::S_END;
                    end
                    else if (pos_reg == pac_pkg::POS_SECOND)
                    begin
                        prev_x_next = ox[OFF_W-1:0];
                        prev_y_next = oy[OFF_W-1:0];
                        pos_next    = pac_pkg::POS_FAN;
                        state_next  = pac_pkg::S_END;
                    end
                    else
                    begin
                        mdu_req.start = 1'b1;
                        mdu_a         = ox;
                        mdu_b         = ppy;
                        state_next    = pac_pkg::S_FAN_M1;
                    end
                end
            end
            pac_pkg::S_FAN_M1:
            begin
                if (mdu_rsp.done)
                begin
                    t1_next       = mdu_res;
                    mdu_req.start = 1'b1;
                    mdu_a         = oy;
                    mdu_b         = ppx;
                    state_next    = pac_pkg::S_FAN_M2;
                end
            end
            pac_pkg::S_FAN_M2:
            begin
                if (mdu_rsp.done)
                begin
                    cross_next = t1_reg - mdu_res;
                    state_next = pac_pkg::S_FAN_AREA;
                end
            end
            pac_pkg::S_FAN_AREA:
            begin
                if (add_bad)
                    err_next = pac_pkg::ST_OVF;
                else
                    area_next = add_sum;
                mdu_req.start = 1'b1;
                mdu_a         = ppx + ox;
                mdu_b         = cross_reg;
                state_next    = pac_pkg::S_FAN_M3;
            end
            pac_pkg::S_FAN_M3:
            begin
                if (mdu_rsp.done)
                    state_next = pac_pkg::S_FAN_MX;
            end
            pac_pkg::S_FAN_MX:
            begin
                if (mdu_rsp.flag || add_bad)
                    err_next = pac_pkg::ST_OVF;
                else
                    mx_next = add_sum;
                mdu_req.start = 1'b1;
                mdu_a         = ppy + oy;
                mdu_b         = cross_reg;
                state_next    = pac_pkg::S_FAN_M4;
            end
            pac_pkg::S_FAN_M4:
            begin
                if (mdu_rsp.done)
                    state_next = pac_pkg::S_FAN_MY;
            end
            pac_pkg::S_FAN_MY:
            begin
                if (mdu_rsp.flag || add_bad)
                    err_next = pac_pkg::ST_OVF;
                else
                    my_next = add_sum;
                prev_x_next = ox[OFF_W-1:0];
                prev_y_next = oy[OFF_W-1:0];
                state_next  = pac_pkg::S_END;
            end
            pac_pkg::S_CLOSE:
            begin
                if (area_reg == '0)
                begin
                    if (err_reg == pac_pkg::ST_OK)
                        err_next = pac_pkg::ST_ZERO;
                    state_next = pac_pkg::S_C_DEN;
                end
                else
                begin
                    if (add_bad)
                        err_next = pac_pkg::ST_OVF;
                    else
                        nx_next = add_sum;
                    state_next = pac_pkg::S_C_ADDY;
                end
            end
            pac_pkg::S_C_ADDY:
            begin
                if (add_bad)
                    err_next = pac_pkg::ST_OVF;
                else
                    ny_next = add_sum;
                mdu_req.start = 1'b1;
                mdu_a         = bx3;
                mdu_b         = area_reg;
                state_next    = pac_pkg::S_C_M1;
            end
            pac_pkg::S_C_M1:
            begin
                if (mdu_rsp.done)
                    state_next = pac_pkg::S_C_ADD1;
            end
            pac_pkg::S_C_ADD1:
            begin
                if (mdu_rsp.flag || add_bad)
                    err_next = pac_pkg::ST_OVF;
                else
                    nx_next = add_sum;
                mdu_req.start = 1'b1;
                mdu_a         = by3;
                mdu_b         = area_reg;
                state_next    = pac_pkg::S_C_M2;
            end
            pac_pkg::S_C_M2:
            begin
                if (mdu_rsp.done)
                    state_next = pac_pkg::S_C_ADD2;
            end
            pac_pkg::S_C_ADD2:
            begin
                if (mdu_rsp.flag || add_bad)
                    err_next = pac_pkg::ST_OVF;
                else
                    ny_next = add_sum;
                state_next = pac_pkg::S_C_DEN;
            end
            pac_pkg::S_C_DEN:
            begin
                // zero-area ring skips the sum; adder sees area 0 there anyway
                if (area_reg != '0)
                begin
                    if (add_bad)
                        err_next = pac_pkg::ST_OVF;
                    else
                        den_next = add_sum;
                end
                pos_next    = pac_pkg::POS_BASE;
                area_next   = '0;
                mx_next     = '0;
                my_next     = '0;
                prev_x_next = '0;
                prev_y_next = '0;
                state_next  = pac_pkg::S_END;
            end
            pac_pkg::S_END:
            begin
                rx_next = '0;
                ry_next = '0;
                if (!last_reg)
                    state_next = pac_pkg::S_IDLE;
                else if (!is_area_type)
                begin
                    st_next    = pac_pkg::ST_NOT_AREA;
                    state_next = pac_pkg::S_OUT;
                end
                else if (err_reg != pac_pkg::ST_OK)
                begin
                    st_next    = err_reg;
                    state_next = pac_pkg::S_OUT;
                end
                else if ((d3w[W+1] != d3w[W-1]) || (d3w[W] != d3w[W-1]))
                begin
                    st_next    = pac_pkg::ST_OVF;
                    state_next = pac_pkg::S_OUT;
                end
                else if (d3w == '0)
                begin
                    st_next    = pac_pkg::ST_ZERO;
                    state_next = pac_pkg::S_OUT;
                end
                else
                begin
                    st_next       = pac_pkg::ST_OK;
                    d3_next       = d3w[W-1:0];
                    mdu_req.start = 1'b1;
                    mdu_req.op    = pac_pkg::MDU_DIV;
                    mdu_a         = nx_reg;
                    mdu_b         = d3w[W-1:0];
                    state_next    = pac_pkg::S_DIV_X;
                end
            end
            pac_pkg::S_DIV_X:
            begin
                if (mdu_rsp.done)
                begin
                    rx_next       = sat_val;
                    mdu_req.start = 1'b1;
                    mdu_req.op    = pac_pkg::MDU_DIV;
                    mdu_a         = ny_reg;
                    mdu_b         = d3_reg;
                    state_next    = pac_pkg::S_DIV_Y;
                end
            end
            pac_pkg::S_DIV_Y:
            begin
                if (mdu_rsp.done)
                begin
                    ry_next    = sat_val;
                    state_next = pac_pkg::S_OUT;
                end
            end
            pac_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_x_next     = rx_reg;
                    out_y_next     = ry_reg;
                    out_st_next    = st_reg;
                    out_valid_next = 1'b1;
                    nx_next        = '0;
                    ny_next        = '0;
                    den_next       = '0;
                    err_next       = pac_pkg::ST_OK;
                    base_x_next    = '0;
                    base_y_next    = '0;
                    state_next     = pac_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pac_pkg::S_IDLE;
            end
        endcase
    end

    // state and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pac_pkg::S_IDLE;
            pos_reg       <= pac_pkg::POS_BASE;
            err_reg       <= pac_pkg::ST_OK;
            type_reg      <= pac_pkg::TYPE_RESET;
            out_valid_reg <= 1'b0;
            base_x_reg    <= '0;
            base_y_reg    <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            area_reg      <= '0;
            mx_reg        <= '0;
            my_reg        <= '0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            den_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            err_reg       <= err_next;
            type_reg      <= type_next;
            out_valid_reg <= out_valid_next;
            base_x_reg    <= base_x_next;
            base_y_reg    <= base_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            area_reg      <= area_next;
            mx_reg        <= mx_next;
            my_reg        <= my_next;
            nx_reg        <= nx_next;
            ny_reg        <= ny_next;
            den_reg       <= den_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        last_reg   <= last_next;
        t1_reg     <= t1_next;
        cross_reg  <= cross_next;
        d3_reg     <= d3_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        st_reg     <= st_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_st_reg <= out_st_next;
    end

endmodule

FILE: rtl/pac_checker.sv
// port-level checks of the polygon area and centroid block, bound to the top level
module pac_checker #(
    parameter int COORD_BITS = pac_pkg::COORD_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [COORD_BITS-1:0] cx,
    input logic signed [COORD_BITS-1:0] cy,
    input logic [1:0]                  status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cx) && $stable(cy) && $stable(status))
        else $error("result changed while stalled");

    // a failed result carries a zero centroid
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != pac_pkg::ST_OK) |-> (cx == '0) && (cy == '0))
        else $error("failed result with nonzero centroid");

    // after each vertex request the block is not ready in the next cycle
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("vertex accepted back to back");

    // a new result only comes out of work in progress
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind polygon_area_centroid pac_checker #(.COORD_BITS(COORD_BITS)) u_pac_checker (.*);
